// ===== src/counting_semaphore_bank_top_defines.svh =====
// assertion macros shared by the checker
`ifndef COUNTING_SEMAPHORE_BANK_TOP_DEFINES_SVH
`define COUNTING_SEMAPHORE_BANK_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define CSB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== src/csb_pkg.sv =====
`default_nettype none

package csb_pkg;

  localparam int SEMAPHORES = 16;
  localparam int THREADS    = 16;

  // field widths of the items
  localparam int CMD_W   = 2;
  localparam int SID_W   = 4;
  localparam int TID_W   = 4;
  localparam int INIT_W  = 31;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 32;
  // list pointer: a thread id or the end marker
  localparam int PTR_W   = TID_W + 1;

  localparam logic [PTR_W-1:0] PTR_NIL = PTR_W'(THREADS);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ERROR   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 2'd2;

  localparam logic WAKE_SIGNAL = 1'b0;
  localparam logic WAKE_CLOSED = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SID_W-1:0]  sem_index;
    logic [TID_W-1:0]  thread_id;
    logic [INIT_W-1:0] initial_count;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SID_W-1:0]  sem_handle;
    logic              wake_valid;
    logic [TID_W-1:0]  woken_thread;
    logic              wake_code;
    logic              last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the request
    logic exec;     // run the captured command, emit its first result
    logic step;     // emit the next waiter of a close
    logic walking;  // a close walk is in progress
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // result register can take a result this cycle
    logic more;     // the close walk has waiters left after this one
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/csb_ctrl.sv =====
`default_nettype none

module csb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  csb_pkg::dp_status_t stat,
  output csb_pkg::ctrl_cmd_t  cmd
);
  import csb_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    WALK
  } state_t;

  state_t state;

  assign req_stall = (state != IDLE);

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == IDLE) && req_valid;
    cmd.exec    = (state == EXEC) && stat.out_free;
    cmd.step    = (state == WALK) && stat.out_free;
    cmd.walking = (state == WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) state <= EXEC;
        end
        EXEC: begin
          if (stat.out_free) state <= stat.more ? WALK : IDLE;
        end
        WALK: begin
          if (stat.out_free && !stat.more) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/csb_datapath.sv =====
`default_nettype none

module csb_datapath (
  input  logic                clk,
  input  logic                rst,
  input  csb_pkg::req_t       req,
  input  csb_pkg::ctrl_cmd_t  cmd,
  output csb_pkg::dp_status_t stat,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output csb_pkg::rsp_t       rsp
);
  import csb_pkg::*;

  // state stores
  logic [SEMAPHORES-1:0]     slot_open;
  logic [THREADS-1:0]        waiting;
  logic signed [COUNT_W-1:0] sem_count   [SEMAPHORES];
  logic [PTR_W-1:0]          list_head   [SEMAPHORES];
  logic [PTR_W-1:0]          thread_link [THREADS];

  // captured request and walk registers
  req_t             req_r;
  logic [PTR_W-1:0] walk_ptr;
  logic [TID_W-1:0] walk_cnt;

  logic out_valid;
  rsp_t out_r;

  // combinational read side
  logic                      free_found;
  logic [SID_W-1:0]          free_idx;
  logic                      slot_ok;
  logic signed [COUNT_W-1:0] cnt;
  logic signed [COUNT_W-1:0] cnt_dec;
  logic signed [COUNT_W-1:0] cnt_inc;
  logic [PTR_W-1:0]          head;
  logic                      head_valid;
  logic [PTR_W-1:0]          cur;
  logic [PTR_W-1:0]          cur_next;
  logic [TID_W-1:0]          cur_idx;
  logic                      cur_last;

  // write controls
  logic                      emit;
  rsp_t                      rsp_next;
  logic                      open_set;
  logic                      open_clr;
  logic                      wait_set;
  logic                      wait_clr;
  logic [TID_W-1:0]          wait_clr_id;
  logic                      cnt_we;
  logic signed [COUNT_W-1:0] cnt_wd;
  logic                      head_we;
  logic [PTR_W-1:0]          head_wd;
  logic                      link_we;
  logic                      walk_load;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SEMAPHORES - 1; i >= 0; i--) begin
      if (!slot_open[i]) begin
        free_found = 1'b1;
        free_idx   = SID_W'(i);
      end
    end
  end

  assign slot_ok    = ({1'b0, req_r.sem_index} < (SID_W + 1)'(SEMAPHORES))
                      && slot_open[req_r.sem_index];
  assign cnt        = sem_count[req_r.sem_index];
  assign cnt_dec    = (cnt == COUNT_MIN) ? cnt : cnt - COUNT_W'(1);
  assign cnt_inc    = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
  assign head       = list_head[req_r.sem_index];
  assign head_valid = (head < PTR_NIL);

  // waiter being reported: head at the start of a close, then the walk pointer
  assign cur      = cmd.walking ? walk_ptr : head;
  assign cur_idx  = cmd.walking ? walk_cnt : '0;
  assign cur_next = thread_link[cur[TID_W-1:0]];
  assign cur_last = (cur_next >= PTR_NIL) || (cur_idx == TID_W'(THREADS - 1));

  assign stat.out_free = !out_valid || !rsp_stall;
  assign stat.more     = cmd.walking ? !cur_last
                         : ((req_r.command == CMD_CLOSE) && slot_ok && head_valid
                            && !cur_last);

  always_comb begin
    emit        = 1'b0;
    rsp_next    = '0;
    rsp_next.last = 1'b1;
    open_set    = 1'b0;
    open_clr    = 1'b0;
    wait_set    = 1'b0;
    wait_clr    = 1'b0;
    wait_clr_id = cur[TID_W-1:0];
    cnt_we      = 1'b0;
    cnt_wd      = cnt;
    head_we     = 1'b0;
    head_wd     = PTR_NIL;
    link_we     = 1'b0;
    walk_load   = 1'b0;

    if (cmd.step) begin
      emit                  = 1'b1;
      rsp_next.wake_valid   = 1'b1;
      rsp_next.woken_thread = cur[TID_W-1:0];
      rsp_next.wake_code    = WAKE_CLOSED;
      rsp_next.last         = cur_last;
      wait_clr              = 1'b1;
      walk_load             = 1'b1;
    end else if (cmd.exec) begin
      emit = 1'b1;
      if (req_r.command == CMD_CREATE) begin
        if (free_found) begin
          rsp_next.sem_handle = free_idx;
          open_set            = 1'b1;
        end else begin
          rsp_next.status = ST_ERROR;
        end
      end else if (!slot_ok) begin
        rsp_next.status = ST_ERROR;
      end else begin
        case (req_r.command)
          CMD_CLOSE: begin
            open_clr = 1'b1;
            head_we  = 1'b1;
            head_wd  = PTR_NIL;
            if (head_valid) begin
              rsp_next.wake_valid   = 1'b1;
              rsp_next.woken_thread = cur[TID_W-1:0];
              rsp_next.wake_code    = WAKE_CLOSED;
              rsp_next.last         = cur_last;
              wait_clr              = 1'b1;
              walk_load             = 1'b1;
            end
          end
          CMD_WAIT: begin
            if (({1'b0, req_r.thread_id} >= PTR_NIL) || waiting[req_r.thread_id]) begin
              rsp_next.status = ST_ERROR;
            end else begin
              cnt_we = 1'b1;
              cnt_wd = cnt_dec;
              if (cnt_dec[COUNT_W-1]) begin
                rsp_next.status = ST_BLOCKED;
                link_we  = 1'b1;
                head_we  = 1'b1;
                head_wd  = {1'b0, req_r.thread_id};
                wait_set = 1'b1;
              end
            end
          end
          CMD_SIGNAL: begin
            cnt_we = 1'b1;
            cnt_wd = cnt_inc;
            if ((cnt_inc[COUNT_W-1] || (cnt_inc == '0)) && head_valid) begin
              rsp_next.wake_valid   = 1'b1;
              rsp_next.woken_thread = head[TID_W-1:0];
              rsp_next.wake_code    = WAKE_SIGNAL;
              head_we               = 1'b1;
              head_wd               = thread_link[head[TID_W-1:0]];
              wait_clr              = 1'b1;
              wait_clr_id           = head[TID_W-1:0];
            end
          end
          default: begin
            rsp_next.status = ST_ERROR;
          end
        endcase
      end
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open <= '0;
      waiting   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (open_set) slot_open[free_idx] <= 1'b1;
      if (open_clr) slot_open[req_r.sem_index] <= 1'b0;
      if (wait_set) waiting[req_r.thread_id] <= 1'b1;
      if (wait_clr) waiting[wait_clr_id] <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!rsp_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload stores
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= req;
    if (open_set) begin
      sem_count[free_idx] <= {1'b0, req_r.initial_count};
      list_head[free_idx] <= PTR_NIL;
    end
    if (cnt_we)  sem_count[req_r.sem_index] <= cnt_wd;
    if (head_we) list_head[req_r.sem_index] <= head_wd;
    if (link_we) thread_link[req_r.thread_id] <= head;
    if (walk_load) begin
      walk_ptr <= cur_next;
      walk_cnt <= cur_idx + TID_W'(1);
    end
    if (emit) out_r <= rsp_next;
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_r;

endmodule

`default_nettype wire

// ===== src/counting_semaphore_bank_top.sv =====
// channel | direction | payload      | handshake
// req     | inbound   | csb_pkg::req_t | req_valid / req_stall
// rsp     | outbound  | csb_pkg::rsp_t | rsp_valid / rsp_stall
//
// a command is captured in the idle state, then the execute state runs the
// read-modify-write of the slot and thread stores and loads the result register
// a close emits one result per waiter, or a single result if none, after capture
// rsp_stall holds the result register and so holds the execute and walk steps
// the result register lets the next item be captured while a result waits
// reset clears the open-slot and waiting-thread bits at once, no clearing pass
`default_nettype none

module counting_semaphore_bank_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  csb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output csb_pkg::rsp_t rsp
);
  import csb_pkg::*;

  // command and status between controller and datapath
  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // sequencer: idle, execute, close walk
  csb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot stores, wait lists, result register
  csb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== src/csb_checker.sv =====
`default_nettype none

`include "counting_semaphore_bank_top_defines.svh"

module csb_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input csb_pkg::rsp_t rsp
);
  import csb_pkg::*;

  // a stalled result holds
  `CSB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // the block is busy in the cycle after it takes an item
  `CSB_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

  // a wake is always an ok result
  `CSB_ASSERT_NOW(a_wake_ok, rsp_valid && rsp.wake_valid, rsp.status == ST_OK)

  // error and blocked results end their command
  `CSB_ASSERT_NOW(a_single_last,
    rsp_valid && ((rsp.status == ST_ERROR) || (rsp.status == ST_BLOCKED)),
    rsp.last && !rsp.wake_valid && (rsp.sem_handle == '0))

  // no wake fields without a wake
  `CSB_ASSERT_NOW(a_wake_fields, rsp_valid && !rsp.wake_valid,
    (rsp.woken_thread == '0) && (rsp.wake_code == WAKE_SIGNAL) && rsp.last)

endmodule

bind counting_semaphore_bank_top csb_checker u_csb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
